### rtl/pid_antiwindup_controller_assert.svh
// assertion macros for the pid anti-windup controller checker
// needs clk and arst_n in scope where used
`ifndef PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH
`define PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PIDAW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PIDAW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/pidaw_pkg.sv
// shared types and constants of the pid anti-windup controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

	localparam int unsigned ADDR_W = 5;

	typedef logic [ADDR_W-1:0] paddr_t;
	typedef logic [2:0] reg_idx_t;
	typedef logic [1:0] clamp_t;

	localparam reg_idx_t REG_PROP_GAIN   = 3'd0;
	localparam reg_idx_t REG_INTEG_GAIN  = 3'd1;
	localparam reg_idx_t REG_DERIV_GAIN  = 3'd2;
	localparam reg_idx_t REG_INTEG_UPPER = 3'd3;
	localparam reg_idx_t REG_INTEG_LOWER = 3'd4;
	localparam reg_idx_t REG_OUT_UPPER   = 3'd5;
	localparam reg_idx_t REG_OUT_LOWER   = 3'd6;

	localparam clamp_t CLAMP_NONE = 2'd0;
	localparam clamp_t CLAMP_HIGH = 2'd1;
	localparam clamp_t CLAMP_LOW  = 2'd2;

	localparam logic signed [31:0] LIMIT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] LIMIT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

### rtl/pid_antiwindup_controller.sv
// pid controller with clamped integrator, clamped output and anti-windup
// depends on pidaw_pkg
//
// usage: each input request carries setpoint, measured and restart on a
// valid/ready channel; each one gives exactly one result request (drive,
// deviation, clamp_status, integ_frozen) on the output valid/ready channel.
// gains and limits sit behind an apb-style port (pready tied high), register
// i at byte address 4*i; write them only while the block is idle.
// a request accepted into the input register is worked out in a single pass
// and its result is then held in the result register.
// throughput: one request per cycle while the output does not stall, set by
// the combinational path through the three multipliers, the integrator clamp
// and the output clamp into the integrator register.
// stall: while the output is held the result register keeps its request and
// the input register can still take one more; input ready then drops.
// reset: gains clear to zero, limits open to the full 32-bit range, the
// integrator and previous feedback clear and both channels are empty.
`timescale 1ns / 1ps
`default_nettype none

module pid_antiwindup_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire pidaw_pkg::paddr_t   paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  setpoint,
	input  wire logic signed [15:0]  measured,
	input  wire logic                restart,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       drive,
	output logic signed [16:0]       deviation,
	output pidaw_pkg::clamp_t        clamp_status,
	output logic                     integ_frozen
);
	import pidaw_pkg::*;

	logic signed [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [31:0] integ_upper_q, integ_lower_q, out_upper_q, out_lower_q;
	logic signed [31:0] integ_acc_q;
	logic signed [15:0] prev_measured_q;

	logic               valid_s1;
	logic signed [15:0] setpoint_s1, measured_s1;
	logic               restart_s1;

	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic signed [16:0] deviation_q;
	clamp_t             clamp_q;
	logic               frozen_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	logic     adv_s1;

	logic signed [16:0] err;
	logic signed [16:0] dfb;
	logic signed [32:0] p_term, i_prod, d_prod;
	logic signed [33:0] cand_raw, d_term;
	logic signed [31:0] cand;
	logic signed [34:0] u_raw;
	logic signed [31:0] u_clamped;
	clamp_t             status;
	logic               frozen;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			integ_upper_q <= LIMIT_MAX;
			integ_lower_q <= LIMIT_MIN;
			out_upper_q   <= LIMIT_MAX;
			out_lower_q   <= LIMIT_MIN;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PROP_GAIN:   prop_gain_q   <= pwdata[15:0];
				REG_INTEG_GAIN:  integ_gain_q  <= pwdata[15:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= pwdata[15:0];
				REG_INTEG_UPPER: integ_upper_q <= pwdata;
				REG_INTEG_LOWER: integ_lower_q <= pwdata;
				REG_OUT_UPPER:   out_upper_q   <= pwdata;
				REG_OUT_LOWER:   out_lower_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PROP_GAIN:   prdata = 32'(prop_gain_q);
			REG_INTEG_GAIN:  prdata = 32'(integ_gain_q);
			REG_DERIV_GAIN:  prdata = 32'(deriv_gain_q);
			REG_INTEG_UPPER: prdata = integ_upper_q;
			REG_INTEG_LOWER: prdata = integ_lower_q;
			REG_OUT_UPPER:   prdata = out_upper_q;
			REG_OUT_LOWER:   prdata = out_lower_q;
			default:         prdata = '0;
		endcase
	end

	// handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
			restart_s1  <= restart;
		end
	end

	// control law
	always_comb begin
		err      = 17'(setpoint_s1) - 17'(measured_s1);
		dfb      = 17'(measured_s1) - 17'(prev_measured_q);
		p_term   = 33'(prop_gain_q) * 33'(err);
		i_prod   = 33'(integ_gain_q) * 33'(err);
		d_prod   = 33'(deriv_gain_q) * 33'(dfb);
		d_term   = -34'(d_prod);
		cand_raw = 34'(integ_acc_q) + 34'(i_prod);

		if (cand_raw > 34'(integ_upper_q)) begin
			cand = integ_upper_q;
		end else if (cand_raw < 34'(integ_lower_q)) begin
			cand = integ_lower_q;
		end else begin
			cand = cand_raw[31:0];
		end

		u_raw  = 35'(p_term) + 35'(cand) + 35'(d_term);
		frozen = 1'b0;
		if (u_raw > 35'(out_upper_q)) begin
			u_clamped = out_upper_q;
			status    = CLAMP_HIGH;
			frozen    = (err > 17'sd0);
		end else if (u_raw < 35'(out_lower_q)) begin
			u_clamped = out_lower_q;
			status    = CLAMP_LOW;
			frozen    = (err < 17'sd0);
		end else begin
			u_clamped = u_raw[31:0];
			status    = CLAMP_NONE;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_acc_q     <= '0;
			prev_measured_q <= '0;
		end else if (adv_s1) begin
			prev_measured_q <= measured_s1;
			if (restart_s1) begin
				integ_acc_q <= '0;
			end else if (!frozen) begin
				integ_acc_q <= cand;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (restart_s1) begin
				drive_q     <= '0;
				deviation_q <= '0;
				clamp_q     <= CLAMP_NONE;
				frozen_q    <= 1'b0;
			end else begin
				drive_q     <= u_clamped;
				deviation_q <= err;
				clamp_q     <= status;
				frozen_q    <= frozen;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign deviation    = deviation_q;
	assign clamp_status = clamp_q;
	assign integ_frozen = frozen_q;

endmodule

`default_nettype wire

### rtl/pidaw_checker.sv
// port-level checks of the pid anti-windup controller, bound to the top level
// depends on pidaw_pkg and pid_antiwindup_controller_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "pid_antiwindup_controller_assert.svh"

module pidaw_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                psel,
	input wire logic                penable,
	input wire logic                pwrite,
	input wire pidaw_pkg::paddr_t   paddr,
	input wire logic [31:0]         pwdata,
	input wire logic [31:0]         prdata,
	input wire logic                pready,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic signed [15:0]  setpoint,
	input wire logic signed [15:0]  measured,
	input wire logic                restart,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic signed [31:0]  drive,
	input wire logic signed [16:0]  deviation,
	input wire pidaw_pkg::clamp_t   clamp_status,
	input wire logic                integ_frozen
);
	import pidaw_pkg::*;

	// a held result request keeps its drive, deviation and clamp status
	`PIDAW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(drive) && $stable(deviation) && $stable(clamp_status))

	// integrator only freezes on a clamped output
	`PIDAW_ASSERT_NOW(a_frozen_clamped, out_valid && integ_frozen,
		clamp_status != CLAMP_NONE)

	// freezing high needs a positive deviation
	`PIDAW_ASSERT_NOW(a_frozen_high, out_valid && integ_frozen && clamp_status == CLAMP_HIGH,
		!deviation[16] && deviation != 17'sd0)

	// freezing low needs a negative deviation
	`PIDAW_ASSERT_NOW(a_frozen_low, out_valid && integ_frozen && clamp_status == CLAMP_LOW,
		deviation[16])

endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (.*);

`default_nettype wire
